FILE: design/round_robin_scheduler_unit_defines.svh
// assertion macros shared by the round-robin scheduler rtl
`ifndef ROUND_ROBIN_SCHEDULER_UNIT_DEFINES_SVH
`define ROUND_ROBIN_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RRS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication, checked out of reset
`define RRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

FILE: design/rrs_pkg.sv
// shared types and constants of the round-robin scheduler
package rrs_pkg;

  // fixed field widths of the stream items
  localparam int unsigned PID_W      = 4;
  localparam int unsigned BURST_IN_W = 16;
  localparam int unsigned OUT_TIME_W = 32;
  localparam int unsigned ERR_W      = 2;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned QUANTUM_W  = 8;
  localparam int unsigned SLICE_W    = 8;

  // apb register map
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_QUANTUM = 1'b0;
  localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 8'd4;

  // parameter defaults
  localparam int unsigned NUM_PROCS_DEF  = 16;
  localparam int unsigned TIME_BITS_DEF  = 32;
  localparam int unsigned BURST_BITS_DEF = 16;

  // item kinds
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_DUP  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ZERO = 2'd2;

  // one result item
  typedef struct packed {
    logic [ERR_W-1:0]      err;
    logic [OUT_TIME_W-1:0] wt;
    logic [OUT_TIME_W-1:0] tat;
    logic [OUT_TIME_W-1:0] finish;
    logic                  done;
    logic [PID_W-1:0]      run_pid;
    logic                  ran;
  } res_t;

endpackage

FILE: design/rrs_ram.sv
// generic single-port-write ram with a registered read
module rrs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/round_robin_scheduler_unit.sv
// round-robin scheduler: arrivals and idle ticks go to the result stage; a
// running tick chains run-queue read, process-table read and write-back,
// result stage; a rotating tick first moves the head to the tail (a lone
// process skips the run-queue re-read); one item at a time, result appears in
// the output register once free; reset clears queue pointers, time, slice and
// in-system flags, quantum = 4; tables not cleared, only read for ids in system
`include "round_robin_scheduler_unit_defines.svh"

module round_robin_scheduler_unit #(
  parameter int unsigned NUM_PROCS  = rrs_pkg::NUM_PROCS_DEF,
  parameter int unsigned TIME_BITS  = rrs_pkg::TIME_BITS_DEF,
  parameter int unsigned BURST_BITS = rrs_pkg::BURST_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pid [3:0], burst [19:4], zero fill [23:20]
  input  logic [rrs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // cmd [0]
  input  logic                             s_axis_tuser,
  // result items
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // ran [0], run_pid [4:1], done_res [5], finish_time [37:6],
  // turnaround [69:38], waiting [101:70], error [103:102]
  output logic [rrs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rrs_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rrs_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rrs_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  import rrs_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_PROCS);
  localparam int unsigned CNT_W = $clog2(NUM_PROCS + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned PM_W  = TIME_BITS + 2 * BURST_BITS;
  localparam logic [SUM_W-1:0] NPROC_S = SUM_W'(NUM_PROCS);
  localparam logic [CNT_W-1:0] NPROC_C = CNT_W'(NUM_PROCS);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROT  = 3'd1;
  localparam logic [2:0] ST_RUN  = 3'd2;
  localparam logic [2:0] ST_PM   = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // circular queue slot: base plus offset, wrapped once
  function automatic logic [IDX_W-1:0] wrap_slot(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] offs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offs);
    if (sum >= NPROC_S) begin
      sum = sum - NPROC_S;
    end
    return IDX_W'(sum);
  endfunction

  logic [2:0]            state_q, state_d;
  logic [IDX_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [SLICE_W-1:0]    slice_q, slice_d;
  logic [TIME_BITS-1:0]  time_q, time_d;
  logic [QUANTUM_W-1:0]  quantum_q;
  logic [NUM_PROCS-1:0]  in_sys_q, in_sys_d;
  logic [IDX_W-1:0]      pid_q, pid_d;
  res_t                  res_q, res_d;
  logic [TIME_BITS-1:0]  tat_q, tat_d;
  logic [BURST_BITS-1:0] burst_q, burst_d;
  logic                  out_valid_q, out_valid_d;
  res_t                  out_q, out_d;

  // ram ports
  logic                  rq_we, rq_re;
  logic [IDX_W-1:0]      rq_waddr, rq_raddr, rq_wdata, rq_rdata;
  logic                  pm_we, pm_re;
  logic [IDX_W-1:0]      pm_waddr, pm_raddr;
  logic [PM_W-1:0]       pm_wdata, pm_rdata;

  // input item fields
  logic                  in_acc;
  logic                  cmd_in;
  logic [PID_W-1:0]      pid_in;
  logic [BURST_BITS-1:0] burst_in;
  logic [IDX_W-1:0]      pid_idx;
  logic                  pid_ok;
  logic [QUANTUM_W-1:0]  q_eff;
  logic                  rotate;

  // process table fields
  logic [BURST_BITS-1:0] pm_rem, pm_burst, pm_rem_n;
  logic [TIME_BITS-1:0]  pm_arr, time_n;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign cmd_in   = s_axis_tuser;
  assign pid_in   = s_axis_tdata[PID_W-1:0];
  assign burst_in = BURST_BITS'(s_axis_tdata[PID_W +: BURST_IN_W]);
  assign pid_idx  = IDX_W'(pid_in);
  assign pid_ok   = 32'(pid_in) < NUM_PROCS;

  // a zero quantum acts as one
  assign q_eff  = (quantum_q == '0) ? QUANTUM_W'(1) : quantum_q;
  assign rotate = (count_q != '0) && (slice_q >= q_eff);

  // process table word: {arrival, burst, remaining}
  assign pm_rem   = pm_rdata[BURST_BITS-1:0];
  assign pm_burst = pm_rdata[BURST_BITS +: BURST_BITS];
  assign pm_arr   = pm_rdata[2*BURST_BITS +: TIME_BITS];
  assign pm_rem_n = (pm_rem != '0) ? pm_rem - BURST_BITS'(1) : pm_rem;
  assign time_n   = time_q + TIME_BITS'(1);

  assign s_axis_tready = (state_q == ST_IDLE);

  // sequencer and read-modify-write of the tables
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    slice_d     = slice_q;
    time_d      = time_q;
    in_sys_d    = in_sys_q;
    pid_d       = pid_q;
    res_d       = res_q;
    tat_d       = tat_q;
    burst_d     = burst_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    rq_we       = 1'b0;
    rq_waddr    = head_q;
    rq_wdata    = pid_idx;
    rq_re       = 1'b0;
    rq_raddr    = head_q;
    pm_we       = 1'b0;
    pm_waddr    = pid_idx;
    pm_wdata    = {time_q, burst_in, burst_in};
    pm_re       = 1'b0;
    pm_raddr    = rq_rdata;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_d   = '0;
          tat_d   = '0;
          burst_d = '0;
          if (cmd_in == CMD_ARRIVE) begin
            // duplicate id wins over zero burst
            if (!pid_ok || in_sys_q[pid_idx]) begin
              res_d.err = ERR_DUP;
            end else if (burst_in == '0) begin
              res_d.err = ERR_ZERO;
            end else if (count_q != NPROC_C) begin
              rq_we             = 1'b1;
              rq_waddr          = wrap_slot(head_q, count_q);
              pm_we             = 1'b1;
              in_sys_d[pid_idx] = 1'b1;
              count_d           = count_q + CNT_W'(1);
            end
            state_d = ST_DONE;
          end else if (count_q == '0) begin
            // idle tick: time moves on, slice restarts
            time_d  = time_n;
            slice_d = '0;
            state_d = ST_DONE;
          end else begin
            rq_re   = 1'b1;
            rq_raddr = head_q;
            state_d = rotate ? ST_ROT : ST_RUN;
          end
        end
      end
      ST_ROT: begin
        // move the head entry to the tail
        rq_we    = 1'b1;
        rq_waddr = wrap_slot(head_q, count_q);
        rq_wdata = rq_rdata;
        head_d   = wrap_slot(head_q, CNT_W'(1));
        slice_d  = '0;
        if (count_q == CNT_W'(1)) begin
          // lone process rotates to itself
          pid_d    = rq_rdata;
          pm_re    = 1'b1;
          pm_raddr = rq_rdata;
          state_d  = ST_PM;
        end else begin
          rq_re    = 1'b1;
          rq_raddr = wrap_slot(head_q, CNT_W'(1));
          state_d  = ST_RUN;
        end
      end
      ST_RUN: begin
        pid_d    = rq_rdata;
        pm_re    = 1'b1;
        pm_raddr = rq_rdata;
        state_d  = ST_PM;
      end
      ST_PM: begin
        // run the head for one unit
        pm_we         = 1'b1;
        pm_waddr      = pid_q;
        pm_wdata      = {pm_arr, pm_burst, pm_rem_n};
        time_d        = time_n;
        slice_d       = slice_q + SLICE_W'(1);
        res_d.ran     = 1'b1;
        res_d.run_pid = PID_W'(pid_q);
        if (pm_rem_n == '0) begin
          res_d.done      = 1'b1;
          res_d.finish    = OUT_TIME_W'(time_n);
          tat_d           = time_n - pm_arr;
          burst_d         = pm_burst;
          in_sys_d[pid_q] = 1'b0;
          head_d          = wrap_slot(head_q, CNT_W'(1));
          count_d         = count_q - CNT_W'(1);
          slice_d         = '0;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_q || m_axis_tready) begin
          out_d       = res_q;
          out_d.tat   = OUT_TIME_W'(tat_q);
          out_d.wt    = OUT_TIME_W'(TIME_BITS'(tat_q - TIME_BITS'(burst_q)));
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      slice_q     <= '0;
      time_q      <= '0;
      in_sys_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      slice_q     <= slice_d;
      time_q      <= time_d;
      in_sys_q    <= in_sys_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pid_q   <= pid_d;
    res_q   <= res_d;
    tat_q   <= tat_d;
    burst_q <= burst_d;
    out_q   <= out_d;
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_QUANTUM)) begin
      quantum_q <= pwdata[QUANTUM_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_QUANTUM) ? APB_DATA_W'(quantum_q) : '0;

  // run queue of process ids
  rrs_ram #(
    .Width(IDX_W),
    .Depth(NUM_PROCS)
  ) u_run_queue (
    .clk_i  (clk_i),
    .we_i   (rq_we),
    .waddr_i(rq_waddr),
    .wdata_i(rq_wdata),
    .re_i   (rq_re),
    .raddr_i(rq_raddr),
    .rdata_o(rq_rdata)
  );

  // per-process table
  rrs_ram #(
    .Width(PM_W),
    .Depth(NUM_PROCS)
  ) u_proc_table (
    .clk_i  (clk_i),
    .we_i   (pm_we),
    .waddr_i(pm_waddr),
    .wdata_i(pm_wdata),
    .re_i   (pm_re),
    .raddr_i(pm_raddr),
    .rdata_o(pm_rdata)
  );

  // output item
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.err, out_q.wt, out_q.tat, out_q.finish,
                          out_q.done, out_q.run_pid, out_q.ran};

  // checks
  `RRS_ASSERT_IMPL(a_count_matches_flags, 1'b1, $countones(in_sys_q) == int'(count_q))
  `RRS_ASSERT_NEXT(a_accept_leaves_idle, s_axis_tvalid && s_axis_tready, state_q != ST_IDLE)
  `RRS_ASSERT_IMPL(a_done_only_when_ran, m_axis_tvalid && out_q.done, out_q.ran && (out_q.err == ERR_NONE))

endmodule
